// ----- hw/rtl/stack_blur_rgb_frame_assert.svh -----
// ----------------------------------------------------------------------------
// Stack blur frame assertion macros
// Property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_BLUR_RGB_FRAME_ASSERT_SVH
`define STACK_BLUR_RGB_FRAME_ASSERT_SVH

// same-cycle implication
`define SBRF_ASSERT_SAME(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbrf assertion failed");

// next-cycle implication
`define SBRF_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbrf assertion failed");

`endif

// ----- hw/rtl/sbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack blur frame package
// Shared constants, controller states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sbrf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 63;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int QUO_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int WIDTH_W    = 9;
    localparam int HEIGHT_W   = 9;
    localparam int RADIUS_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = CFG_IDX_W'(2);

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(256);
    localparam logic [RADIUS_W-1:0] RST_RADIUS = RADIUS_W'(1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_BLUR_INIT,
        ST_LINE_SETUP,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_INIT_RD,
        ST_INIT_ACC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT_WR,
        ST_UPD_L,
        ST_UPD_E,
        ST_UPD_M,
        ST_NEXT_LINE
    } state_t;

    typedef struct packed {
        logic load_px;
        logic fetch_rd;
        logic fetch_out;
        logic blur_init;
        logic line_setup;
        logic copy_rd;
        logic copy_wr;
        logic init_rd;
        logic init_acc;
        logic div_load;
        logic div_step;
        logic out_wr;
        logic upd_l;
        logic upd_e;
        logic upd_m;
        logic next_line;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic copy_last;
        logic init_last;
        logic div_last;
        logic x_last;
        logic line_last;
        logic pass_v;
    } status_t;

endpackage

// ----- hw/rtl/sbrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stack blur frame controller
// Sequences loads, fetches and the two blur passes over the stored frame.
// ----------------------------------------------------------------------------
module sbrf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    input  sbrf_pkg::status_t stat,
    output sbrf_pkg::cmd_t    cmd,
    output logic              busy
);
    import sbrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_FETCH)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (stat.load_last)
                    begin
                        state_next = ST_BLUR_INIT;
                    end
                end
            end
            ST_FETCH:      state_next = ST_IDLE;
            ST_BLUR_INIT:  state_next = ST_LINE_SETUP;
            ST_LINE_SETUP: state_next = ST_COPY_RD;
            ST_COPY_RD:    state_next = ST_COPY_WR;
            ST_COPY_WR:    state_next = stat.copy_last ? ST_INIT_RD : ST_COPY_RD;
            ST_INIT_RD:    state_next = ST_INIT_ACC;
            ST_INIT_ACC:   state_next = stat.init_last ? ST_DIV_LOAD : ST_INIT_RD;
            ST_DIV_LOAD:   state_next = ST_DIV;
            ST_DIV:        state_next = stat.div_last ? ST_OUT_WR : ST_DIV;
            ST_OUT_WR:     state_next = ST_UPD_L;
            ST_UPD_L:      state_next = ST_UPD_E;
            ST_UPD_E:      state_next = ST_UPD_M;
            ST_UPD_M:      state_next = stat.x_last ? ST_NEXT_LINE : ST_DIV_LOAD;
            ST_NEXT_LINE:
            begin
                if (stat.line_last && stat.pass_v)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LINE_SETUP;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.load_px  = start && (op == OP_LOAD);
                cmd.fetch_rd = start && (op == OP_FETCH);
            end
            ST_FETCH:      cmd.fetch_out  = 1'b1;
            ST_BLUR_INIT:  cmd.blur_init  = 1'b1;
            ST_LINE_SETUP: cmd.line_setup = 1'b1;
            ST_COPY_RD:    cmd.copy_rd    = 1'b1;
            ST_COPY_WR:    cmd.copy_wr    = 1'b1;
            ST_INIT_RD:    cmd.init_rd    = 1'b1;
            ST_INIT_ACC:   cmd.init_acc   = 1'b1;
            ST_DIV_LOAD:   cmd.div_load   = 1'b1;
            ST_DIV:        cmd.div_step   = 1'b1;
            ST_OUT_WR:     cmd.out_wr     = 1'b1;
            ST_UPD_L:      cmd.upd_l      = 1'b1;
            ST_UPD_E:      cmd.upd_e      = 1'b1;
            ST_UPD_M:      cmd.upd_m      = 1'b1;
            ST_NEXT_LINE:  cmd.next_line  = 1'b1;
            default:       busy           = 1'b1;
        endcase
    end

endmodule

// ----- hw/rtl/sbrf_datapath.sv -----
// ----------------------------------------------------------------------------
// Stack blur frame datapath
// Frame and line memories, running kernel sums, divider and result registers.
// ----------------------------------------------------------------------------
module sbrf_datapath #(
    parameter int MAX_WIDTH  = sbrf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbrf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sbrf_pkg::DEF_MAX_RADIUS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbrf_pkg::cmd_t                    cmd,
    output sbrf_pkg::status_t                 stat,
    input  logic [sbrf_pkg::PIX_W-1:0]        pixel_in,
    input  logic                              cfg_we,
    input  logic [sbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              result_valid,
    output logic [sbrf_pkg::PIX_W-1:0]        pixel_out,
    output logic                              last_pixel,
    output logic                              status
);
    import sbrf_pkg::*;

    localparam int LINE_LEN    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CW          = $clog2(FRAME_DEPTH + 1);
    localparam int LA_W        = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int LEN_W       = $clog2(LINE_LEN + 1);
    localparam int RW          = $clog2(MAX_RADIUS + 1);
    localparam int R1_W        = RW + 1;
    localparam int IW          = ((LEN_W > R1_W) ? LEN_W : R1_W) + 2;
    localparam int DS_W        = 2 * R1_W;
    localparam int WS_W        = CH_W + DS_W;
    localparam int ES_W        = CH_W + R1_W;
    localparam int SW          = $clog2(QUO_W);

    localparam logic signed [IW-1:0] ONE_S  = IW'(1);
    localparam logic signed [IW-1:0] ZERO_S = IW'(0);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [CW-1:0]       lc_reg;
    logic [CW-1:0]       fc_reg;
    logic                done_reg;
    logic                fetch_ok_reg;

    logic                pass_v_reg;
    logic [LEN_W-1:0]    line_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       caddr_reg;
    logic [AW-1:0]       waddr_reg;
    logic [LEN_W-1:0]    k_reg;
    logic [LEN_W-1:0]    x_reg;
    logic signed [IW-1:0] i_reg;

    logic [WS_W-1:0]     ws_reg  [3];
    logic [ES_W-1:0]     es_reg  [3];
    logic [ES_W-1:0]     ls_reg  [3];
    logic [WS_W-1:0]     rem_reg [3];
    logic [QUO_W-1:0]    q_reg   [3];
    logic [WS_W-1:0]     dsh_reg;
    logic [SW-1:0]       step_reg;

    logic [PIX_W-1:0]    frame_mem [FRAME_DEPTH];
    logic [PIX_W-1:0]    frame_rdata_reg;
    logic [PIX_W-1:0]    line_mem  [LINE_LEN];
    logic [PIX_W-1:0]    line_rdata_reg;

    logic                result_valid_reg;
    logic [PIX_W-1:0]    pixel_out_reg;
    logic                last_pixel_reg;
    logic                status_reg;

    logic [LEN_W-1:0]    w_eff;
    logic [LEN_W-1:0]    h_eff;
    logic [RW-1:0]       r_eff;
    logic [CW-1:0]       total;
    logic [CW-1:0]       la;
    logic [CW-1:0]       la_inc;
    logic [LEN_W-1:0]    n_len;
    logic [LEN_W-1:0]    n_m1;
    logic [LEN_W-1:0]    n_lines;
    logic [AW-1:0]       stride;
    logic [AW-1:0]       row_step;
    logic signed [IW-1:0] r_s;
    logic signed [IW-1:0] x_s;
    logic signed [IW-1:0] nm1_s;
    logic signed [IW-1:0] abs_i;
    logic signed [IW-1:0] wt_s;
    logic [R1_W-1:0]     weight;
    logic [R1_W-1:0]     r1;
    logic [DS_W-1:0]     divsum;
    logic [CH_W-1:0]     vch [3];

    logic                frame_re;
    logic [AW-1:0]       frame_raddr;
    logic                frame_we;
    logic [AW-1:0]       frame_waddr;
    logic [PIX_W-1:0]    frame_wdata;
    logic                line_re;
    logic [LA_W-1:0]     line_raddr;

    function automatic logic [LA_W-1:0] clampi(input logic signed [IW-1:0] v,
                                               input logic signed [IW-1:0] hi);
        logic [LA_W-1:0] res;
        if (v[IW-1])
        begin
            res = '0;
        end
        else if (v > hi)
        begin
            res = LA_W'(hi);
        end
        else
        begin
            res = LA_W'(v);
        end
        return res;
    endfunction

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = LEN_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = LEN_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = LEN_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = LEN_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = LEN_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = LEN_W'(height_reg);
        end

        if (32'(radius_reg) > 32'(MAX_RADIUS))
        begin
            r_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            r_eff = RW'(radius_reg);
        end
    end

    assign total    = CW'(CW'(w_eff) * CW'(h_eff));
    assign la       = done_reg ? '0 : lc_reg;
    assign la_inc   = la + CW'(1);
    assign n_len    = pass_v_reg ? h_eff : w_eff;
    assign n_lines  = pass_v_reg ? w_eff : h_eff;
    assign n_m1     = n_len - LEN_W'(1);
    assign stride   = pass_v_reg ? AW'(w_eff) : AW'(1);
    assign row_step = pass_v_reg ? AW'(1) : AW'(w_eff);

    assign r_s   = $signed(IW'(r_eff));
    assign x_s   = $signed(IW'(x_reg));
    assign nm1_s = $signed(IW'(n_m1));
    assign abs_i = i_reg[IW-1] ? -i_reg : i_reg;
    assign wt_s  = r_s + ONE_S - abs_i;
    assign weight = R1_W'(wt_s);

    assign r1     = R1_W'(r_eff) + R1_W'(1);
    assign divsum = DS_W'(r1) * DS_W'(r1);

    assign vch[0] = line_rdata_reg[23:16];
    assign vch[1] = line_rdata_reg[15:8];
    assign vch[2] = line_rdata_reg[7:0];

    assign stat.load_last = (la_inc == total);
    assign stat.copy_last = (k_reg == n_m1);
    assign stat.init_last = (i_reg == r_s);
    assign stat.div_last  = (step_reg == SW'(QUO_W - 1));
    assign stat.x_last    = (x_reg == n_m1);
    assign stat.line_last = (line_reg == (n_lines - LEN_W'(1)));
    assign stat.pass_v    = pass_v_reg;

    // memory port muxes
    assign frame_re    = cmd.fetch_rd || cmd.copy_rd;
    assign frame_raddr = cmd.fetch_rd ? fc_reg[AW-1:0] : caddr_reg;
    assign frame_we    = cmd.load_px || cmd.out_wr;
    assign frame_waddr = cmd.load_px ? la[AW-1:0] : waddr_reg;
    assign frame_wdata = cmd.load_px ? pixel_in
                       : {line_rdata_reg[31:24], q_reg[0], q_reg[1], q_reg[2]};

    assign line_re = cmd.init_rd || cmd.div_load || cmd.out_wr || cmd.upd_l || cmd.upd_e;

    always_comb
    begin
        if (cmd.init_rd)
        begin
            line_raddr = clampi(i_reg, nm1_s);
        end
        else if (cmd.div_load)
        begin
            line_raddr = LA_W'(x_reg);
        end
        else if (cmd.out_wr)
        begin
            line_raddr = clampi(x_s - r_s, nm1_s);
        end
        else if (cmd.upd_l)
        begin
            line_raddr = clampi(x_s + r_s + ONE_S, nm1_s);
        end
        else
        begin
            line_raddr = clampi(x_s + ONE_S, nm1_s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_re)
        begin
            frame_rdata_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy_wr)
        begin
            line_mem[k_reg[LA_W-1:0]] <= frame_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_re)
        begin
            line_rdata_reg <= line_mem[line_raddr];
        end
    end

    // config, frame bookkeeping and line sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            radius_reg   <= RST_RADIUS;
            lc_reg       <= '0;
            fc_reg       <= '0;
            done_reg     <= 1'b0;
            fetch_ok_reg <= 1'b0;
            pass_v_reg   <= 1'b0;
            line_reg     <= '0;
            base_reg     <= '0;
            caddr_reg    <= '0;
            waddr_reg    <= '0;
            k_reg        <= '0;
            x_reg        <= '0;
            i_reg        <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:
                    begin
                        width_reg <= cfg_data[WIDTH_W-1:0];
                        lc_reg    <= '0;
                        fc_reg    <= '0;
                        done_reg  <= 1'b0;
                    end
                    CFG_FRAME_HEIGHT:
                    begin
                        height_reg <= cfg_data[HEIGHT_W-1:0];
                        lc_reg     <= '0;
                        fc_reg     <= '0;
                        done_reg   <= 1'b0;
                    end
                    CFG_BLUR_RADIUS:
                    begin
                        radius_reg <= cfg_data[RADIUS_W-1:0];
                        lc_reg     <= '0;
                        fc_reg     <= '0;
                        done_reg   <= 1'b0;
                    end
                    default:
                    begin
                        lc_reg <= lc_reg;
                    end
                endcase
            end

            if (cmd.load_px)
            begin
                lc_reg   <= la_inc;
                fc_reg   <= '0;
                done_reg <= 1'b0;
            end

            if (cmd.fetch_rd)
            begin
                fetch_ok_reg <= done_reg && (fc_reg < total);
            end

            if (cmd.fetch_out && fetch_ok_reg)
            begin
                fc_reg <= fc_reg + CW'(1);
            end

            if (cmd.blur_init)
            begin
                pass_v_reg <= 1'b0;
                line_reg   <= '0;
                base_reg   <= '0;
            end

            if (cmd.line_setup)
            begin
                caddr_reg <= base_reg;
                waddr_reg <= base_reg;
                k_reg     <= '0;
                x_reg     <= '0;
                i_reg     <= -r_s;
            end

            if (cmd.copy_wr)
            begin
                caddr_reg <= caddr_reg + stride;
                k_reg     <= k_reg + LEN_W'(1);
            end

            if (cmd.init_acc)
            begin
                i_reg <= i_reg + ONE_S;
            end

            if (cmd.div_load)
            begin
                step_reg <= '0;
            end

            if (cmd.div_step)
            begin
                step_reg <= step_reg + SW'(1);
            end

            if (cmd.out_wr)
            begin
                waddr_reg <= waddr_reg + stride;
            end

            if (cmd.upd_m)
            begin
                x_reg <= x_reg + LEN_W'(1);
            end

            if (cmd.next_line)
            begin
                if (stat.line_last)
                begin
                    if (pass_v_reg)
                    begin
                        done_reg <= 1'b1;
                        fc_reg   <= '0;
                    end
                    else
                    begin
                        pass_v_reg <= 1'b1;
                        line_reg   <= '0;
                        base_reg   <= '0;
                    end
                end
                else
                begin
                    line_reg <= line_reg + LEN_W'(1);
                    base_reg <= base_reg + row_step;
                end
            end
        end
    end

    // running sums and divider
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dsh_reg <= WS_W'(divsum) << (QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
        end

        for (int c = 0; c < 3; c++)
        begin
            if (cmd.line_setup)
            begin
                ws_reg[c] <= '0;
                es_reg[c] <= '0;
                ls_reg[c] <= '0;
            end
            else if (cmd.init_acc)
            begin
                ws_reg[c] <= ws_reg[c] + WS_W'(vch[c]) * WS_W'(weight);
                if (i_reg > ZERO_S)
                begin
                    es_reg[c] <= es_reg[c] + ES_W'(vch[c]);
                end
                else
                begin
                    ls_reg[c] <= ls_reg[c] + ES_W'(vch[c]);
                end
            end
            else if (cmd.out_wr)
            begin
                ws_reg[c] <= ws_reg[c] - WS_W'(ls_reg[c]);
            end
            else if (cmd.upd_l)
            begin
                ls_reg[c] <= ls_reg[c] - ES_W'(vch[c]);
            end
            else if (cmd.upd_e)
            begin
                es_reg[c] <= es_reg[c] + ES_W'(vch[c]);
                ws_reg[c] <= ws_reg[c] + WS_W'(es_reg[c]) + WS_W'(vch[c]);
            end
            else if (cmd.upd_m)
            begin
                ls_reg[c] <= ls_reg[c] + ES_W'(vch[c]);
                es_reg[c] <= es_reg[c] - ES_W'(vch[c]);
            end

            if (cmd.div_load)
            begin
                rem_reg[c] <= ws_reg[c];
                q_reg[c]   <= '0;
            end
            else if (cmd.div_step)
            begin
                if (rem_reg[c] >= dsh_reg)
                begin
                    rem_reg[c] <= rem_reg[c] - dsh_reg;
                    q_reg[c]   <= {q_reg[c][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[c]   <= {q_reg[c][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // result port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.fetch_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_out)
        begin
            if (fetch_ok_reg)
            begin
                pixel_out_reg  <= frame_rdata_reg;
                last_pixel_reg <= ((fc_reg + CW'(1)) == total);
                status_reg     <= STATUS_OK;
            end
            else
            begin
                pixel_out_reg  <= '0;
                last_pixel_reg <= 1'b0;
                status_reg     <= STATUS_NOT_READY;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign last_pixel   = last_pixel_reg;
    assign status       = status_reg;

endmodule

// ----- hw/rtl/stack_blur_rgb_frame.sv -----
// ----------------------------------------------------------------------------
// Stack blur RGB frame - loads and fetches are taken while idle; a fetch goes
// via the FETCH state to the result register. Blur follows the last load, mostly
// in the bit-serial pixel divider. Receiver cannot stall; results are never held.
// Reset: async, empty frame, 256x256, radius 1.
// ----------------------------------------------------------------------------
`include "stack_blur_rgb_frame_assert.svh"

module stack_blur_rgb_frame #(
    parameter int MAX_WIDTH  = sbrf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbrf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sbrf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [sbrf_pkg::PIX_W-1:0]      pixel_in,
    output logic                            result_valid,
    output logic [sbrf_pkg::PIX_W-1:0]      pixel_out,
    output logic                            last_pixel,
    output logic                            status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbrf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbrf_pkg::*;

    cmd_t    cmd;
    status_t stat;
    logic    cfg_we;

    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    sbrf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sbrf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .pixel_in     (pixel_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .last_pixel   (last_pixel),
        .status       (status)
    );

    `SBRF_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
    `SBRF_ASSERT_SAME(a_not_ready_zero, result_valid && status, (pixel_out == '0) && !last_pixel)
    `SBRF_ASSERT_NEXT(a_fetch_busy, start && !busy && op, busy && !result_valid)

endmodule
